>>> hdl/assert_macros.svh
// Assertion macros for the top-level converter, the only asserting RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define STBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("stbc assertion failed");

// A condition in one cycle that implies a consequence in the next.
`define STBC_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("stbc assertion failed");

`endif

>>> hdl/stbc_pkg.sv
// Package with the types and constants of the scaled time base converter.
`default_nettype none
package stbc_pkg;
    localparam int VALUE_W    = 64;
    localparam int FACTOR_W   = 20;
    localparam int SMALL_BITS = 44;
    localparam int DIV_STAGES = 64;

    localparam logic [1:0] MODE_SYSTEM  = 2'd0;
    localparam logic [1:0] MODE_CUSTOM  = 2'd1;
    localparam logic [1:0] MODE_STRETCH = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_NUM    = 3'd1;
    localparam logic [2:0] REG_DEN    = 3'd2;
    localparam logic [2:0] REG_START  = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;
    localparam logic [2:0] REG_CUSTOM = 3'd5;

    localparam logic CMD_TIMESTAMP = 1'b0;
    localparam logic CMD_DURATION  = 1'b1;

    // Register contents as seen by the datapath.
    typedef struct packed {
        logic [1:0]          mode;
        logic [FACTOR_W-1:0] num;
        logic [FACTOR_W-1:0] den;
        logic [VALUE_W-1:0]  start;
        logic [VALUE_W-1:0]  offset;
        logic [VALUE_W-1:0]  custom;
    } cfg_t;

    // Control that travels with an item alongside the divider.
    typedef struct packed {
        logic               neg;
        logic               mul_after;
        logic               add_start;
        logic               bypass;
        logic [VALUE_W-1:0] bypass_value;
    } side_t;
endpackage
`default_nettype wire

>>> hdl/stbc_front.sv
// Front end: decodes the transaction and forms the unsigned dividend.
`default_nettype none
module stbc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic                          cmd,
    input  wire logic [stbc_pkg::VALUE_W-1:0]  in_value,
    input  wire stbc_pkg::cfg_t                cfg,
    output logic                               valid,
    output logic [stbc_pkg::VALUE_W-1:0]       dividend,
    output stbc_pkg::side_t                    side
);
    logic                          v1_reg;
    logic [stbc_pkg::VALUE_W-1:0]  src_reg;
    logic [stbc_pkg::VALUE_W-1:0]  prod_reg;
    logic                          small_reg;
    stbc_pkg::side_t               side1_reg;
    stbc_pkg::side_t               side1_next;
    logic                          small_next;
    logic                          v2_reg;
    logic [stbc_pkg::VALUE_W-1:0]  div_reg;
    stbc_pkg::side_t               side2_reg;
    stbc_pkg::side_t               side2_next;
    logic [stbc_pkg::VALUE_W-1:0]  src_abs;

    // Decode the command and mode into the path the item takes.
    always_comb
    begin
        side1_next = '0;
        small_next = 1'b0;
        case (cfg.mode)
            stbc_pkg::MODE_SYSTEM:
            begin
                side1_next.bypass       = 1'b1;
                side1_next.bypass_value = in_value;
            end
            stbc_pkg::MODE_CUSTOM:
            begin
                side1_next.bypass       = 1'b1;
                side1_next.bypass_value = (cmd == stbc_pkg::CMD_TIMESTAMP) ? cfg.custom
                                                                           : in_value;
            end
            stbc_pkg::MODE_STRETCH:
            begin
                if (cmd == stbc_pkg::CMD_TIMESTAMP)
                begin
                    side1_next.mul_after = 1'b1;
                    side1_next.add_start = 1'b1;
                end
                else if (in_value[stbc_pkg::VALUE_W-1:stbc_pkg::SMALL_BITS] == '0)
                begin
                    small_next = 1'b1;
                end
                else
                begin
                    side1_next.mul_after = 1'b1;
                end
            end
            default:
            begin
                side1_next.bypass       = 1'b1;
                side1_next.bypass_value = '0;
            end
        endcase
    end

    // First stage: offset removal and the small-value product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src_reg   <= (cmd == stbc_pkg::CMD_TIMESTAMP)
                         ? (in_value - cfg.start - cfg.offset) : in_value;
            prod_reg  <= in_value[stbc_pkg::SMALL_BITS-1:0] * cfg.num;
            small_reg <= small_next;
            side1_reg <= side1_next;
        end
    end

    // Second stage: sign and magnitude of the dividend.
    assign src_abs = src_reg[stbc_pkg::VALUE_W-1] ? (~src_reg + 1'b1) : src_reg;

    // The sign is restored later only for a divided signed value.
    always_comb
    begin
        side2_next     = side1_reg;
        side2_next.neg = !small_reg && src_reg[stbc_pkg::VALUE_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg   <= small_reg ? prod_reg : src_abs;
            side2_reg <= side2_next;
        end
    end

    assign valid    = v2_reg;
    assign dividend = div_reg;
    assign side     = side2_reg;
endmodule
`default_nettype wire

>>> hdl/stbc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module stbc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [stbc_pkg::VALUE_W-1:0]  dividend,
    input  wire stbc_pkg::side_t               in_side,
    input  wire logic [stbc_pkg::FACTOR_W-1:0] den,
    output logic                               valid,
    output logic [stbc_pkg::VALUE_W-1:0]       quotient,
    output stbc_pkg::side_t                    side
);
    localparam int N = stbc_pkg::DIV_STAGES;
    localparam int W = stbc_pkg::VALUE_W;
    localparam int F = stbc_pkg::FACTOR_W;

    logic            valid_reg [N];
    logic [W-1:0]    word_reg  [N];
    logic [F-1:0]    rem_reg   [N];
    stbc_pkg::side_t side_reg  [N];

    for (genvar gi = 0; gi < N; gi++)
    begin : g_stage
        logic            v_in;
        logic [W-1:0]    w_in;
        logic [F-1:0]    r_in;
        stbc_pkg::side_t s_in;
        logic [F:0]      trial;
        logic [F:0]      diff;
        logic            ge;

        if (gi == 0)
        begin : g_first
            assign v_in = in_valid;
            assign w_in = dividend;
            assign r_in = '0;
            assign s_in = in_side;
        end
        else
        begin : g_next
            assign v_in = valid_reg[gi-1];
            assign w_in = word_reg[gi-1];
            assign r_in = rem_reg[gi-1];
            assign s_in = side_reg[gi-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor.
        assign trial = {r_in, w_in[W-1]};
        assign diff  = trial - {1'b0, den};
        assign ge    = trial >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[gi] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[gi] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                word_reg[gi] <= {w_in[W-2:0], ge};
                rem_reg[gi]  <= ge ? diff[F-1:0] : trial[F-1:0];
                side_reg[gi] <= s_in;
            end
        end
    end

    assign valid    = valid_reg[N-1];
    assign quotient = word_reg[N-1];
    assign side     = side_reg[N-1];
endmodule
`default_nettype wire

>>> hdl/stbc_back.sv
// Back end: scales the quotient, restores the sign, adds the start time or selects the bypass value.
`default_nettype none
module stbc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [stbc_pkg::VALUE_W-1:0]  quotient,
    input  wire stbc_pkg::side_t               in_side,
    input  wire logic [stbc_pkg::FACTOR_W-1:0] num,
    input  wire logic [stbc_pkg::VALUE_W-1:0]  start,
    output logic                               valid,
    output logic [stbc_pkg::VALUE_W-1:0]       value
);
    localparam int W = stbc_pkg::VALUE_W;
    localparam int H = W / 2;
    localparam int F = stbc_pkg::FACTOR_W;

    logic            v1_reg;
    logic [H+F-1:0]  lo_reg;
    logic [H-1:0]    hi_reg;
    logic [W-1:0]    q1_reg;
    stbc_pkg::side_t s1_reg;
    logic [H+F-1:0]  hi_full;

    logic            v2_reg;
    logic [W-1:0]    m_reg;
    stbc_pkg::side_t s2_reg;

    logic            v3_reg;
    logic [W-1:0]    r_reg;
    stbc_pkg::side_t s3_reg;

    logic            out_valid_reg;
    logic [W-1:0]    out_value_reg;

    assign hi_full = quotient[W-1:H] * num;

    // Valid bits of the back-end stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Partial products, their sum, sign and start offset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= quotient[H-1:0] * num;
            hi_reg <= hi_full[H-1:0];
            q1_reg <= quotient;
            s1_reg <= in_side;

            m_reg  <= s1_reg.mul_after
                      ? ({hi_reg, {H{1'b0}}} + {{(W-H-F){1'b0}}, lo_reg}) : q1_reg;
            s2_reg <= s1_reg;

            r_reg  <= s2_reg.neg ? (~m_reg + 1'b1) : m_reg;
            s3_reg <= s2_reg;

            out_value_reg <= s3_reg.bypass ? s3_reg.bypass_value
                             : (r_reg + (s3_reg.add_start ? start : {W{1'b0}}));
        end
    end

    assign valid = out_valid_reg;
    assign value = out_value_reg;
endmodule
`default_nettype wire

>>> hdl/scaled_time_base_converter.sv
// Depth is set by the 64-stage divider between the front end and the back end.
// Throughput: one transaction per cycle while the output is not stalled.
// The whole pipeline advances together whenever the output register is free.
// Reset clears all valid bits and loads the register reset values at once.
// No clearing pass; input is accepted from the first cycle after reset.
`default_nettype none
`include "assert_macros.svh"
module scaled_time_base_converter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [stbc_pkg::VALUE_W-1:0]   cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           cmd,
    input  wire logic [stbc_pkg::VALUE_W-1:0]   in_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [stbc_pkg::VALUE_W-1:0]        out_value
);
    stbc_pkg::cfg_t                 cfg_reg;
    stbc_pkg::cfg_t                 cfg_eff;
    logic                           en;
    logic                           f_valid;
    logic [stbc_pkg::VALUE_W-1:0]   f_dividend;
    stbc_pkg::side_t                f_side;
    logic                           d_valid;
    logic [stbc_pkg::VALUE_W-1:0]   d_quotient;
    stbc_pkg::side_t                d_side;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            cfg_reg.num    <= stbc_pkg::FACTOR_W'(1);
            cfg_reg.den    <= stbc_pkg::FACTOR_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stbc_pkg::REG_MODE:   cfg_reg.mode   <= cfg_data[1:0];
                stbc_pkg::REG_NUM:    cfg_reg.num    <= cfg_data[stbc_pkg::FACTOR_W-1:0];
                stbc_pkg::REG_DEN:    cfg_reg.den    <= cfg_data[stbc_pkg::FACTOR_W-1:0];
                stbc_pkg::REG_START:  cfg_reg.start  <= cfg_data;
                stbc_pkg::REG_OFFSET: cfg_reg.offset <= cfg_data;
                stbc_pkg::REG_CUSTOM: cfg_reg.custom <= cfg_data;
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // A zero denominator divides by one.
    always_comb
    begin
        cfg_eff = cfg_reg;
        if (cfg_reg.den == '0)
        begin
            cfg_eff.den = stbc_pkg::FACTOR_W'(1);
        end
    end

    // The pipeline moves whenever the output register can take a result.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    stbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_value (in_value),
        .cfg      (cfg_eff),
        .valid    (f_valid),
        .dividend (f_dividend),
        .side     (f_side)
    );

    stbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .dividend (f_dividend),
        .in_side  (f_side),
        .den      (cfg_eff.den),
        .valid    (d_valid),
        .quotient (d_quotient),
        .side     (d_side)
    );

    stbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid),
        .quotient (d_quotient),
        .in_side  (d_side),
        .num      (cfg_eff.num),
        .start    (cfg_eff.start),
        .valid    (out_valid),
        .value    (out_value)
    );

    // The divider never sees a zero divisor.
    `STBC_ASSERT(a_den_nonzero, cfg_eff.den != '0)
    // A result that waits keeps its value until it is taken.
    `STBC_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_value))
    // A stalled pipeline keeps its front-end valid bit.
    `STBC_ASSERT_NEXT(a_front_holds, f_valid && !en, f_valid)
endmodule
`default_nettype wire
